### design/fpasmd_pkg.sv
// Shared types and constants of the binary32 add/sub/mul/div core.
// No dependencies; used by every module of the core.
package fpasmd_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [31:0] QNAN_BITS = 32'hFFFF_FFFF;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;

  // Quotient bits of the divider and how many are resolved per stage
  localparam int unsigned DivBits     = 27;
  localparam int unsigned DivPerStage = 3;
  localparam int unsigned DivStages   = DivBits / DivPerStage;

  typedef enum logic [1:0] {
    KIND_SPECIAL,
    KIND_ADD,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  // Classified item. For KIND_ADD, a is the operand with the larger exponent.
  typedef struct packed {
    kind_e       kind;
    logic        sign;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] res;
  } item_t;

endpackage

### design/fpasmd_front.sv
// Front end: decodes the command and resolves special operands.
// Depends on fpasmd_pkg.
module fpasmd_front (
  input  logic [1:0]          cmd_i,
  input  logic [31:0]         operand_a_i,
  input  logic [31:0]         operand_b_i,
  output fpasmd_pkg::item_t   item_o
);

  logic [31:0] b_eff;
  logic        sa, sb, sbe;
  logic [7:0]  ea, eb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sub_a, sub_b;
  logic [31:0] big, small_op;
  logic [7:0]  diff;

  assign b_eff = (cmd_i == fpasmd_pkg::CMD_SUB) ? (operand_b_i ^ fpasmd_pkg::SIGN_BIT)
                                                 : operand_b_i;
  assign sa  = operand_a_i[31];
  assign sb  = operand_b_i[31];
  assign sbe = b_eff[31];
  assign ea  = operand_a_i[30:23];
  assign eb  = operand_b_i[30:23];

  assign nan_a  = (ea == 8'hFF) && (operand_a_i[22:0] != '0);
  assign nan_b  = (eb == 8'hFF) && (operand_b_i[22:0] != '0);
  assign inf_a  = (ea == 8'hFF) && (operand_a_i[22:0] == '0);
  assign inf_b  = (eb == 8'hFF) && (operand_b_i[22:0] == '0);
  assign zero_a = (ea == 8'h00) && (operand_a_i[22:0] == '0);
  assign zero_b = (eb == 8'h00) && (operand_b_i[22:0] == '0);
  assign sub_a  = (ea == 8'h00) && (operand_a_i[22:0] != '0);
  assign sub_b  = (eb == 8'h00) && (operand_b_i[22:0] != '0);

  // larger exponent first; a wins on a tie
  assign big      = (ea >= eb) ? operand_a_i : b_eff;
  assign small_op = (ea >= eb) ? b_eff : operand_a_i;
  assign diff     = big[30:23] - small_op[30:23];

  always_comb begin
    item_o.kind = fpasmd_pkg::KIND_SPECIAL;
    item_o.sign = sa ^ sb;
    item_o.a    = operand_a_i;
    item_o.b    = b_eff;
    item_o.res  = '0;
    case (cmd_i)
      fpasmd_pkg::CMD_ADD, fpasmd_pkg::CMD_SUB: begin
        if (nan_a || nan_b) begin
          item_o.res = fpasmd_pkg::QNAN_BITS;
        end else if (inf_a && inf_b && (sa != sbe)) begin
          item_o.res = fpasmd_pkg::QNAN_BITS;
        end else if (inf_a) begin
          item_o.res = {sa, fpasmd_pkg::INF_BITS[30:0]};
        end else if (inf_b) begin
          item_o.res = {sbe, fpasmd_pkg::INF_BITS[30:0]};
        end else if (sub_a || sub_b) begin
          item_o.res = '0;
        end else if (zero_a && zero_b) begin
          item_o.res = {sa & sbe, 31'd0};
        end else if (zero_a) begin
          item_o.res = b_eff;
        end else if (zero_b) begin
          item_o.res = operand_a_i;
        end else if (diff > 8'd25) begin
          item_o.res = big;
        end else begin
          item_o.kind = fpasmd_pkg::KIND_ADD;
          item_o.a    = big;
          item_o.b    = small_op;
        end
      end
      fpasmd_pkg::CMD_MUL: begin
        if (nan_a || nan_b) begin
          item_o.res = fpasmd_pkg::QNAN_BITS;
        end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
          item_o.res = fpasmd_pkg::QNAN_BITS;
        end else if (inf_a || inf_b) begin
          item_o.res = {sa ^ sb, fpasmd_pkg::INF_BITS[30:0]};
        end else if ((ea == 8'h00) || (eb == 8'h00)) begin
          item_o.res = {sa ^ sb, 31'd0};
        end else begin
          item_o.kind = fpasmd_pkg::KIND_MUL;
        end
      end
      default: begin
        if (nan_a || nan_b) begin
          item_o.res = fpasmd_pkg::QNAN_BITS;
        end else if ((inf_a && inf_b) || (zero_a && zero_b)) begin
          item_o.res = fpasmd_pkg::QNAN_BITS;
        end else if (inf_a) begin
          item_o.res = {sa ^ sb, fpasmd_pkg::INF_BITS[30:0]};
        end else if (inf_b) begin
          item_o.res = {sa ^ sb, 31'd0};
        end else if (zero_b) begin
          item_o.res = {sa ^ sb, fpasmd_pkg::INF_BITS[30:0]};
        end else if ((ea == 8'h00) || sub_b) begin
          item_o.res = {sa ^ sb, 31'd0};
        end else begin
          item_o.kind = fpasmd_pkg::KIND_DIV;
        end
      end
    endcase
  end

endmodule

### design/fpasmd_queue.sv
// Small FIFO of classified items between front end and back end.
// Depends on fpasmd_pkg.
module fpasmd_queue #(
  parameter int unsigned Depth = fpasmd_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  fpasmd_pkg::item_t push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output fpasmd_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  fpasmd_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push_fire, pop_fire;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_q <= count_q + 1'b1;
      end else if (!push_fire && pop_fire) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fire && !pop_fire |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

### design/fpasmd_back.sv
// Back end: add/mul/div datapath, pipelined divider, normalize, round, output register.
// Depends on fpasmd_pkg.
module fpasmd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fpasmd_pkg::item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       result_bits_o
);

  localparam int unsigned NSt = fpasmd_pkg::DivStages + 1;

  typedef struct packed {
    logic               spec;
    logic [31:0]        res;
    logic               sign;
    logic signed [10:0] e;
    logic [49:0]        m;
    logic               div;
    logic [23:0]        r;
    logic [26:0]        q;
    logic [23:0]        dvs;
  } pipe_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        res;
    logic               sign;
    logic signed [10:0] e;
    logic [63:0]        n;
    logic [5:0]         lz;
  } norm_t;

  logic  en;
  pipe_t st_d [NSt];
  pipe_t st_q [NSt];
  logic  [NSt-1:0] st_vld_q;
  norm_t n1_d, n1_q, n2_d, n2_q;
  logic  n1_vld_q, n2_vld_q;
  logic  out_vld_q;
  logic  [31:0] result_d, result_q;

  // whole pipe moves when the output register is free or being drained
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // ---- entry stage: align/add, multiply, divider setup
  logic [23:0] sig_a, sig_b;
  logic [7:0]  ea, eb, sh;
  logic [49:0] mb, ms;
  logic [47:0] prod;

  assign sig_a = {1'b1, in_item_i.a[22:0]};
  assign sig_b = {1'b1, in_item_i.b[22:0]};
  assign ea    = in_item_i.a[30:23];
  assign eb    = in_item_i.b[30:23];
  assign sh    = ea - eb;
  assign mb    = {26'd0, sig_a} << sh;
  assign ms    = {26'd0, sig_b};
  assign prod  = sig_a * sig_b;

  always_comb begin
    st_d[0].spec = 1'b0;
    st_d[0].res  = in_item_i.res;
    st_d[0].sign = in_item_i.sign;
    st_d[0].e    = '0;
    st_d[0].m    = '0;
    st_d[0].div  = 1'b0;
    st_d[0].r    = sig_a;
    st_d[0].q    = '0;
    st_d[0].dvs  = sig_b;
    case (in_item_i.kind)
      fpasmd_pkg::KIND_ADD: begin
        st_d[0].e = $signed({3'b000, eb});
        if (in_item_i.a[31] == in_item_i.b[31]) begin
          st_d[0].m    = mb + ms;
          st_d[0].sign = in_item_i.a[31];
        end else if (mb == ms) begin
          // exact cancellation gives +0
          st_d[0].spec = 1'b1;
          st_d[0].res  = '0;
        end else if (mb > ms) begin
          st_d[0].m    = mb - ms;
          st_d[0].sign = in_item_i.a[31];
        end else begin
          st_d[0].m    = ms - mb;
          st_d[0].sign = in_item_i.b[31];
        end
      end
      fpasmd_pkg::KIND_MUL: begin
        st_d[0].m = {2'b00, prod};
        st_d[0].e = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd150;
      end
      fpasmd_pkg::KIND_DIV: begin
        st_d[0].div = 1'b1;
        st_d[0].e   = $signed({3'b000, ea}) - $signed({3'b000, eb}) + 11'sd123;
      end
      default: begin
        st_d[0].spec = 1'b1;
      end
    endcase
  end

  // ---- divider: restoring, DivPerStage quotient bits per stage
  for (genvar j = 0; j < fpasmd_pkg::DivStages; j++) begin : g_div
    always_comb begin
      pipe_t      cur;
      logic [24:0] rs;
      logic        qb;
      cur = st_q[j];
      for (int k = 0; k < fpasmd_pkg::DivPerStage; k++) begin
        if ((j == 0) && (k == 0)) begin
          rs = {1'b0, cur.r};
        end else begin
          rs = {cur.r, 1'b0};
        end
        if (rs >= {1'b0, cur.dvs}) begin
          rs = rs - {1'b0, cur.dvs};
          qb = 1'b1;
        end else begin
          qb = 1'b0;
        end
        cur.r = rs[23:0];
        cur.q = {cur.q[25:0], qb};
      end
      st_d[j+1] = cur;
    end
  end

  // ---- normalize, coarse: whole bytes
  logic [49:0] mm;
  logic [63:0] w;
  logic [2:0]  cb;

  assign mm = st_q[NSt-1].div ? {22'd0, st_q[NSt-1].q, (st_q[NSt-1].r != '0)}
                              : st_q[NSt-1].m;
  assign w  = {mm, 14'd0};

  always_comb begin
    cb = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (w[8*i +: 8] != '0) begin
        cb = 3'(7 - i);
      end
    end
    n1_d.spec = st_q[NSt-1].spec;
    n1_d.res  = st_q[NSt-1].res;
    n1_d.sign = st_q[NSt-1].sign;
    n1_d.e    = st_q[NSt-1].e;
    n1_d.n    = w << {cb, 3'b000};
    n1_d.lz   = {cb, 3'b000};
  end

  // ---- normalize, fine: bits within the top byte
  logic [2:0] fb;

  always_comb begin
    fb = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (n1_q.n[56 + i]) begin
        fb = 3'(7 - i);
      end
    end
    n2_d      = n1_q;
    n2_d.n    = n1_q.n << fb;
    n2_d.lz   = n1_q.lz + {3'b000, fb};
  end

  // ---- round to nearest even and pack
  logic               rnd_up;
  logic [24:0]        k25;
  logic signed [10:0] x, xf;
  logic [22:0]        frac;

  always_comb begin
    rnd_up = n2_q.n[39] && (n2_q.n[40] || (n2_q.n[38:14] != '0));
    k25    = {1'b0, n2_q.n[63:40]} + {24'd0, rnd_up};
    x      = n2_q.e + 11'sd26 - $signed({5'd0, n2_q.lz});
    xf     = k25[24] ? x + 11'sd1 : x;
    frac   = k25[24] ? k25[23:1] : k25[22:0];
    if (n2_q.spec) begin
      result_d = n2_q.res;
    end else if (xf >= 11'sd255) begin
      result_d = {n2_q.sign, fpasmd_pkg::INF_BITS[30:0]};
    end else if (xf <= 11'sd0) begin
      result_d = {n2_q.sign, 31'd0};
    end else begin
      result_d = {n2_q.sign, xf[7:0], frac};
    end
  end

  // ---- registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NSt; i++) begin
        st_q[i] <= (i == 0) ? st_d[0] : st_d[i];
      end
      n1_q     <= n1_d;
      n2_q     <= n2_d;
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q  <= '0;
      n1_vld_q  <= 1'b0;
      n2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      st_vld_q  <= {st_vld_q[NSt-2:0], in_valid_i};
      n1_vld_q  <= st_vld_q[NSt-1];
      n2_vld_q  <= n1_vld_q;
      out_vld_q <= n2_vld_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_bits_o = result_q;

  a_nan_canonical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (result_q[30:23] == 8'hFF) && (result_q[22:0] != '0)
      |-> result_q == fpasmd_pkg::QNAN_BITS)
    else $error("non-canonical NaN on output");

  a_no_subnormal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (result_q[30:23] == 8'h00) |-> result_q[22:0] == '0)
    else $error("subnormal result on output");

endmodule

### design/fp32_add_sub_mul_div_core.sv
// Top level of the binary32 add/sub/mul/div core.
// Depends on fpasmd_pkg, fpasmd_front, fpasmd_queue, fpasmd_back.

// Binary32 add, subtract, multiply and divide, round to nearest even, no
// subnormals (a subnormal input gives zero unless a NaN, an infinity or a
// zero divisor decides first; tiny results flush to signed zero), overflow
// saturates to signed infinity, every NaN comes out as 0xFFFFFFFF. The core
// takes one item per clock while the queue has room and returns one result
// per item, in order. An accepted item is classified and written to a
// QueueDepth-entry queue in the same edge; from the queue head the back end
// passes it through one entry stage (alignment add or 24x24 multiply), nine
// divider stages resolving three quotient bits each, two normalize stages and
// the rounding/output register. Every operation flows through the divider
// stages, so latency is the same for all commands. When the output is not
// taken the back end freezes and the queue absorbs new items until it fills.
module fp32_add_sub_mul_div_core #(
  parameter int unsigned QueueDepth = fpasmd_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_bits_o
);

  fpasmd_pkg::item_t front_item, head_item;
  logic              head_valid, head_ready;

  // decode and special-case resolution, purely combinational
  fpasmd_front u_front (
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .item_o      (front_item)
  );

  // decouples acceptance from back-end stalls
  fpasmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_item_o   (head_item)
  );

  // arithmetic pipeline with output register
  fpasmd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (head_valid),
    .in_ready_o    (head_ready),
    .in_item_i     (head_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_bits_o (result_bits_o)
  );

endmodule
